>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the code table builder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet while reset is high.
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, quiet while reset is high.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/hctb_pkg.sv
// ----------------------------------------------------------------------------
// hctb_pkg
// Shared constants and types of the Huffman code table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hctb_pkg;

   // Defaults of the top level parameters.
   localparam int DEF_MAX_CODE_LEN   = 16;
   localparam int DEF_NUM_COMPONENTS = 3;
   localparam int DEF_NUM_CLASSES    = 2;
   localparam int DEF_SYMBOL_SPACE   = 256;

   // Fixed field widths.
   localparam int OP_W    = 2;
   localparam int CLASS_W = 1;
   localparam int COMP_W  = 2;
   localparam int SLOT_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int SIZE_W  = 5;
   localparam int ASG_W   = 9;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_COUNT  = 2'd0,
      OP_LOAD_SYMBOL = 2'd1,
      OP_BUILD       = 2'd2,
      OP_LOOKUP      = 2'd3
   } op_type;

endpackage

`default_nettype wire

>>> src/hctb_ram.sv
// ----------------------------------------------------------------------------
// hctb_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hctb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/huffman_code_table_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_table_builder
// Holds the JPEG Huffman tables of every class and component, builds their
// canonical codes and answers code lookups.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low, and every
// item gives exactly one result beat, shown for one cycle with rsp_strobe
// high; the receiver cannot stall it, so it must take each beat as it comes.
// Length-count loads, symbol loads and lookups may follow each other in
// every cycle; their beat appears in the cycle after the item is taken.
// The lookup path is one read of the code memory, whose registered output
// drives the result. A build holds busy high while it works, codes at most
// SYMBOL_SPACE symbol positions, and its beat appears in the cycle busy
// falls. First a sweep zeroes the table's code entries, one a cycle; then
// for every code length ST_CNT_RD reads the count, ST_CNT_WAIT waits on
// the memory, then ST_SYM reads the symbol list, one symbol a cycle, and
// closes the length; ST_DONE ends the build. After reset the block sweeps
// all NUM_CLASSES * NUM_COMPONENTS * SYMBOL_SPACE code entries to zero,
// one a cycle, with busy high. A table number that does not exist gives
// an all-zero beat and changes nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_table_builder #(
   parameter int MAX_CODE_LEN   = hctb_pkg::DEF_MAX_CODE_LEN,
   parameter int NUM_COMPONENTS = hctb_pkg::DEF_NUM_COMPONENTS,
   parameter int NUM_CLASSES    = hctb_pkg::DEF_NUM_CLASSES,
   parameter int SYMBOL_SPACE   = hctb_pkg::DEF_SYMBOL_SPACE
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [hctb_pkg::OP_W-1:0]    req_op,
   input  wire logic [hctb_pkg::CLASS_W-1:0] req_coeff_class,
   input  wire logic [hctb_pkg::COMP_W-1:0]  req_component,
   input  wire logic [hctb_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic [hctb_pkg::BYTE_W-1:0]  req_data_byte,
   input  wire logic [hctb_pkg::BYTE_W-1:0]  req_lookup_symbol,
   output logic                             rsp_strobe,
   output logic      [hctb_pkg::WORD_W-1:0]  rsp_code_word,
   output logic      [hctb_pkg::SIZE_W-1:0]  rsp_code_length,
   output logic      [hctb_pkg::ASG_W-1:0]   rsp_symbols_assigned
);

   localparam int NUM_TABLES = NUM_CLASSES * NUM_COMPONENTS;
   localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int LEN_DEPTH  = NUM_TABLES * MAX_CODE_LEN;
   localparam int LEN_AW     = (LEN_DEPTH > 1) ? $clog2(LEN_DEPTH) : 1;
   localparam int CODE_DEPTH = NUM_TABLES * SYMBOL_SPACE;
   localparam int CODE_AW    = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
   localparam int LEN_W      = $clog2(MAX_CODE_LEN + 1);
   localparam int POS_W      = $clog2(SYMBOL_SPACE + 1);
   localparam int ENTRY_W    = hctb_pkg::SIZE_W + hctb_pkg::WORD_W;

   // Build sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_INIT     = 7'b0000010,
      ST_CLEAR    = 7'b0000100,
      ST_CNT_RD   = 7'b0001000,
      ST_CNT_WAIT = 7'b0010000,
      ST_SYM      = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CODE_AW-1:0]            clr_ff, clr_in;
   logic [TBL_W-1:0]              tbl_ff, tbl_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [hctb_pkg::WORD_W-1:0]   code_ff, code_in;
   logic [hctb_pkg::BYTE_W-1:0]   remain_ff, remain_in;

   // One-stage write pipeline: the symbol read issued in one cycle is
   // written into the code memory in the next.
   logic                          wr_pend_ff;
   logic [hctb_pkg::WORD_W-1:0]   wr_code_ff;
   logic [LEN_W-1:0]              wr_len_ff;

   logic                          strobe_ff;
   logic                          lookup_ff;
   logic                          done_ff;

   logic                          accept;
   logic                          tbl_ok;
   logic [TBL_W-1:0]              req_tbl;
   logic                          build_go;
   logic                          issue;

   logic                          len_we;
   logic [LEN_AW-1:0]             len_waddr;
   logic [hctb_pkg::BYTE_W-1:0]   len_wdata;
   logic [LEN_AW-1:0]             len_raddr;
   logic [hctb_pkg::BYTE_W-1:0]   len_rdata;

   logic                          sym_we;
   logic [CODE_AW-1:0]            sym_waddr;
   logic [CODE_AW-1:0]            sym_raddr;
   logic [hctb_pkg::BYTE_W-1:0]   sym_rdata;

   logic                          code_we;
   logic [CODE_AW-1:0]            code_waddr;
   logic [ENTRY_W-1:0]            code_wdata;
   logic [CODE_AW-1:0]            code_raddr;
   logic [ENTRY_W-1:0]            code_rdata;
   logic                          sym_in_range;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The table number exists only for a valid class and component.
   assign tbl_ok  = (32'(req_coeff_class) < NUM_CLASSES)
                 && (32'(req_component) < NUM_COMPONENTS);
   assign req_tbl = TBL_W'(32'(req_coeff_class) * NUM_COMPONENTS + 32'(req_component));

   assign build_go = accept && tbl_ok && (req_op == hctb_pkg::OP_BUILD);
   assign issue    = (state_ff == ST_SYM) && (remain_ff != '0)
                  && (32'(pos_ff) < SYMBOL_SPACE);

   // Length count memory: zeroed by the reset sweep, written by count loads,
   // read once per code length during a build.
   always_comb begin
      if (state_ff == ST_INIT) begin
         len_we    = (32'(clr_ff) < LEN_DEPTH);
         len_waddr = LEN_AW'(clr_ff);
         len_wdata = '0;
      end else begin
         len_we    = accept && tbl_ok && (req_op == hctb_pkg::OP_LOAD_COUNT)
                  && (32'(req_slot) < MAX_CODE_LEN);
         len_waddr = LEN_AW'(32'(req_tbl) * MAX_CODE_LEN + 32'(req_slot));
         len_wdata = req_data_byte;
      end
   end

   assign len_raddr = LEN_AW'(32'(tbl_ff) * MAX_CODE_LEN + 32'(len_ff) - 1);

   hctb_ram #(
      .WIDTH (hctb_pkg::BYTE_W),
      .DEPTH (LEN_DEPTH)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   // Symbol list memory: no reset, written by symbol loads only.
   assign sym_we    = accept && tbl_ok && (req_op == hctb_pkg::OP_LOAD_SYMBOL)
                   && (32'(req_slot) < SYMBOL_SPACE);
   assign sym_waddr = CODE_AW'(32'(req_tbl) * SYMBOL_SPACE + 32'(req_slot));
   assign sym_raddr = CODE_AW'(32'(tbl_ff) * SYMBOL_SPACE + 32'(pos_ff));

   hctb_ram #(
      .WIDTH (hctb_pkg::BYTE_W),
      .DEPTH (CODE_DEPTH)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (sym_waddr),
      .wr_data (req_data_byte),
      .rd_addr (sym_raddr),
      .rd_data (sym_rdata)
   );

   // Code memory: each entry holds {length, code}. Sweeps write zero; the
   // write pipeline stores a code unless the listed symbol lies outside the
   // symbol space, in which case the code is spent without a store.
   assign sym_in_range = (32'(sym_rdata) < SYMBOL_SPACE);

   always_comb begin
      case (state_ff)
         ST_INIT: begin
            code_we    = 1'b1;
            code_waddr = clr_ff;
            code_wdata = '0;
         end
         ST_CLEAR: begin
            code_we    = 1'b1;
            code_waddr = CODE_AW'(32'(tbl_ff) * SYMBOL_SPACE + 32'(clr_ff));
            code_wdata = '0;
         end
         default: begin
            code_we    = wr_pend_ff && sym_in_range;
            code_waddr = CODE_AW'(32'(tbl_ff) * SYMBOL_SPACE + 32'(sym_rdata));
            code_wdata = {hctb_pkg::SIZE_W'(wr_len_ff), wr_code_ff};
         end
      endcase
   end

   assign code_raddr = CODE_AW'(32'(req_tbl) * SYMBOL_SPACE + 32'(req_lookup_symbol));

   hctb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CODE_DEPTH)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (code_waddr),
      .wr_data (code_wdata),
      .rd_addr (code_raddr),
      .rd_data (code_rdata)
   );

   // Build sequencer.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      tbl_in    = tbl_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      code_in   = code_ff;
      remain_in = remain_ff;
      case (state_ff)
         ST_INIT: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CODE_AW'(CODE_DEPTH - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (build_go) begin
               tbl_in   = req_tbl;
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CODE_AW'(SYMBOL_SPACE - 1)) begin
               clr_in   = '0;
               len_in   = LEN_W'(1);
               pos_in   = '0;
               code_in  = '0;
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WAIT;
         end
         ST_CNT_WAIT: begin
            remain_in = len_rdata;
            state_in  = ST_SYM;
         end
         ST_SYM: begin
            if (issue) begin
               pos_in    = pos_ff + 1'b1;
               code_in   = code_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
            end else begin
               // Close this length: the next length starts one bit longer.
               code_in = {code_ff[hctb_pkg::WORD_W-2:0], 1'b0};
               if (len_ff == LEN_W'(MAX_CODE_LEN)) begin
                  state_in = ST_DONE;
               end else begin
                  len_in   = len_ff + 1'b1;
                  state_in = ST_CNT_RD;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         clr_ff     <= '0;
         wr_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
         lookup_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         wr_pend_ff <= issue;
         // Every item but a real build answers in the next cycle.
         strobe_ff  <= (accept && !build_go) || (state_ff == ST_DONE);
         lookup_ff  <= accept && tbl_ok && (req_op == hctb_pkg::OP_LOOKUP)
                    && (32'(req_lookup_symbol) < SYMBOL_SPACE);
         done_ff    <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff     <= tbl_in;
      len_ff     <= len_in;
      pos_ff     <= pos_in;
      code_ff    <= code_in;
      remain_ff  <= remain_in;
      wr_code_ff <= code_ff;
      wr_len_ff  <= len_ff;
   end

   // Result beat. A lookup shows the stored entry; a zero length means the
   // symbol has no code, and then the code word is zero too.
   assign rsp_strobe      = strobe_ff;
   assign rsp_code_length = lookup_ff ? code_rdata[ENTRY_W-1 -: hctb_pkg::SIZE_W] : '0;
   assign rsp_code_word   = (lookup_ff && (code_rdata[ENTRY_W-1 -: hctb_pkg::SIZE_W] != '0))
                          ? code_rdata[hctb_pkg::WORD_W-1:0] : '0;
   assign rsp_symbols_assigned = done_ff ? hctb_pkg::ASG_W'(pos_ff) : '0;

endmodule

`default_nettype wire

>>> src/hctb_checker.sv
// ----------------------------------------------------------------------------
// hctb_checker
// Port-level checks of the Huffman code table builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hctb_checker #(
   parameter int MAX_CODE_LEN = hctb_pkg::DEF_MAX_CODE_LEN
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic [hctb_pkg::OP_W-1:0]   req_op,
   input wire logic                        rsp_strobe,
   input wire logic [hctb_pkg::WORD_W-1:0] rsp_code_word,
   input wire logic [hctb_pkg::SIZE_W-1:0] rsp_code_length,
   input wire logic [hctb_pkg::ASG_W-1:0]  rsp_symbols_assigned
);

   logic taken;
   assign taken = start && !busy;

   // Short items answer in the very next cycle.
   `ASSERT_NEXT(a_short_answers, taken && (req_op != hctb_pkg::OP_BUILD), rsp_strobe)

   // No beat leaves while the block is working on a build or its reset sweep.
   `ASSERT_SAME(a_quiet_busy, busy, !rsp_strobe)

   // Only lookups carry a code.
   `ASSERT_NEXT(a_no_code, taken && (req_op != hctb_pkg::OP_LOOKUP), (rsp_code_length == '0) && (rsp_code_word == '0))

   // A lookup never reports a build count.
   `ASSERT_NEXT(a_lookup_count, taken && (req_op == hctb_pkg::OP_LOOKUP), rsp_symbols_assigned == '0)

   // A beat never shows a code longer than the longest length.
   `ASSERT_SAME(a_len_bound, rsp_strobe, 32'(rsp_code_length) <= MAX_CODE_LEN)

endmodule

bind huffman_code_table_builder hctb_checker #(
   .MAX_CODE_LEN (MAX_CODE_LEN)
) u_hctb_checker (.*);

`default_nettype wire
